FILE: design/ldrs_pkg.sv
package ldrs_pkg;

  localparam int unsigned CellsDefault     = 64;
  localparam int unsigned RowLengthDefault = 16;

  localparam int unsigned IvlW    = 12;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0]      SpaceChar  = 8'h20;
  localparam logic [IvlW-1:0] ScanIvlRst = 12'd3749;
  localparam logic [IvlW-1:0] SettleRst  = 12'd4;
  localparam logic [IvlW-1:0] SetupRst   = 12'd1;
  localparam logic [IvlW-1:0] PulseRst   = 12'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCAN   = 2'd0,
    CFG_SETTLE = 2'd1,
    CFG_SETUP  = 2'd2,
    CFG_PULSE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_CHECK      = 4'd0,
    PH_RS_CMD     = 4'd1,
    PH_HI_NIB     = 4'd2,
    PH_HI_EN_ON   = 4'd3,
    PH_HI_EN_OFF  = 4'd4,
    PH_LO_NIB     = 4'd5,
    PH_LO_EN_ON   = 4'd6,
    PH_LO_EN_OFF  = 4'd7,
    PH_RS_DATA    = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    BIT_KEEP = 2'd0,
    BIT_CLR  = 2'd1,
    BIT_SET  = 2'd2
  } bit_op_e;

  typedef enum logic [1:0] {
    NIB_NONE = 2'd0,
    NIB_HI   = 2'd1,
    NIB_LO   = 2'd2
  } nib_op_e;

  typedef enum logic [1:0] {
    IVL_KEEP   = 2'd0,
    IVL_SETTLE = 2'd1,
    IVL_SETUP  = 2'd2,
    IVL_PULSE  = 2'd3
  } ivl_sel_e;

  typedef enum logic [1:0] {
    JMP_NONE = 2'd0,
    JMP_SCAN = 2'd1,
    JMP_CMD  = 2'd2
  } jmp_e;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_EXEC = 1'b1
  } ctl_state_e;

  typedef struct packed {
    bit_op_e  rs_op;
    bit_op_e  en_op;
    nib_op_e  nib_op;
    ivl_sel_e ivl_sel;
    bit_op_e  cmd_op;
    jmp_e     jmp;
    logic [3:0] next_ph;
  } ucode_t;

  typedef struct packed {
    logic       operation;
    logic [5:0] cell_index;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic            reg_select;
    logic            enable_pin;
    logic [3:0]      data_nibble;
    logic [IvlW-1:0] next_interval;
    logic            refresh_busy;
  } result_t;

  function automatic ucode_t ucode_rom(logic [3:0] ph);
    ucode_t w;
    w = '{rs_op: BIT_KEEP, en_op: BIT_KEEP, nib_op: NIB_NONE, ivl_sel: IVL_KEEP,
          cmd_op: BIT_KEEP, jmp: JMP_NONE, next_ph: PH_CHECK};
    unique case (ph)
      PH_CHECK: begin
        w.jmp     = JMP_SCAN;
        w.next_ph = PH_RS_CMD;
      end
      PH_RS_CMD: begin
        w.rs_op   = BIT_CLR;
        w.ivl_sel = IVL_SETTLE;
        w.cmd_op  = BIT_SET;
        w.next_ph = PH_HI_NIB;
      end
      PH_HI_NIB: begin
        w.nib_op  = NIB_HI;
        w.ivl_sel = IVL_SETUP;
        w.next_ph = PH_HI_EN_ON;
      end
      PH_HI_EN_ON: begin
        w.en_op   = BIT_SET;
        w.ivl_sel = IVL_PULSE;
        w.next_ph = PH_HI_EN_OFF;
      end
      PH_HI_EN_OFF: begin
        w.en_op   = BIT_CLR;
        w.next_ph = PH_LO_NIB;
      end
      PH_LO_NIB: begin
        w.nib_op  = NIB_LO;
        w.ivl_sel = IVL_SETUP;
        w.next_ph = PH_LO_EN_ON;
      end
      PH_LO_EN_ON: begin
        w.en_op   = BIT_SET;
        w.ivl_sel = IVL_PULSE;
        w.next_ph = PH_LO_EN_OFF;
      end
      PH_LO_EN_OFF: begin
        w.en_op   = BIT_CLR;
        w.jmp     = JMP_CMD;
        w.next_ph = PH_RS_DATA;
      end
      PH_RS_DATA: begin
        w.rs_op   = BIT_SET;
        w.ivl_sel = IVL_SETTLE;
        w.cmd_op  = BIT_CLR;
        w.next_ph = PH_HI_NIB;
      end
      default: begin
        w.next_ph = PH_CHECK;
      end
    endcase
    return w;
  endfunction

  function automatic logic [7:0] row_base(logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h90;
      default: b = 8'hD0;
    endcase
    return b;
  endfunction

endpackage

FILE: design/lcd_diff_refresh_sequencer_unit.sv
// channel   direction  handshake                   payload
// item      in         start high, busy low         item_i (ldrs_pkg::item_t)
// result    out        result_valid_o, one cycle    result_o (ldrs_pkg::result_t)
// config    in         cfg_valid_i and cfg_ready_o  cfg_index_i, cfg_data_i
//
// a write item is done when it is taken; a tick item first reads both character
// memories at the scan position, then runs the control word of the phase
// the result strobe comes in the cycle after the item finishes
// reset clears control state and all valid bits, so every cell reads as space
// the receiver cannot stall; config is always ready
module lcd_diff_refresh_sequencer_unit #(
  parameter int unsigned CELLS      = ldrs_pkg::CellsDefault,
  parameter int unsigned ROW_LENGTH = ldrs_pkg::RowLengthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ldrs_pkg::item_t              item_i,
  output logic                         result_valid_o,
  output ldrs_pkg::result_t            result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ldrs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ldrs_pkg::IvlW-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned CW = $clog2(ROW_LENGTH);

  ldrs_pkg::ctl_state_e state_q, state_d;
  ldrs_pkg::phase_e     phase_q, phase_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [AW-1:0]        row_q, row_d;
  logic [CW-1:0]        col_q, col_d;
  logic                 cmd_q, cmd_d;
  logic                 rs_q, rs_d;
  logic                 en_q, en_d;
  logic [3:0]           nib_q, nib_d;
  logic [ldrs_pkg::IvlW-1:0] ivl_q, ivl_d;
  logic                 res_vld_q, res_vld_d;

  logic [ldrs_pkg::IvlW-1:0] scan_ivl_q, settle_ivl_q, setup_ivl_q, pulse_ivl_q;

  logic [7:0] wanted_mem [CELLS];
  logic [7:0] shown_mem  [CELLS];
  logic [CELLS-1:0] w_vld_q, s_vld_q;
  logic [7:0] w_rd_q, s_rd_q;
  logic       w_rd_vld_q, s_rd_vld_q;

  logic          accept, tick_acc, wr_acc, wr_in_range;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wanted_cur, shown_cur;
  logic          w_we, s_we;
  logic [7:0]    w_wdata;
  logic [1:0]    row_sat;
  logic [7:0]    col, addr_cmd, byte_out;
  ldrs_pkg::ucode_t uw;

  assign accept      = start && !busy;
  assign tick_acc    = accept && !item_i.operation;
  assign wr_acc      = accept && item_i.operation;
  assign wr_in_range = 32'(item_i.cell_index) < CELLS;
  assign wr_addr     = AW'(item_i.cell_index);
  assign busy        = (state_q == ldrs_pkg::CTL_EXEC);
  assign cfg_ready_o = 1'b1;

  assign wanted_cur = w_rd_vld_q ? w_rd_q : ldrs_pkg::SpaceChar;
  assign shown_cur  = s_rd_vld_q ? s_rd_q : ldrs_pkg::SpaceChar;

  assign col      = 8'(col_q);
  assign row_sat  = (32'(row_q) > 32'd3) ? 2'd3 : row_q[1:0];
  assign addr_cmd = ldrs_pkg::row_base(row_sat) + col;
  assign byte_out = cmd_q ? addr_cmd : wanted_cur;

  assign uw = ldrs_pkg::ucode_rom(phase_q);

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    row_d     = row_q;
    col_d     = col_q;
    cmd_d     = cmd_q;
    rs_d      = rs_q;
    en_d      = en_q;
    nib_d     = nib_q;
    ivl_d     = ivl_q;
    res_vld_d = 1'b0;
    w_we      = 1'b0;
    s_we      = 1'b0;
    w_wdata   = shown_cur;
    unique case (state_q)
      ldrs_pkg::CTL_IDLE: begin
        if (tick_acc) begin
          state_d = ldrs_pkg::CTL_EXEC;
        end
        if (wr_acc) begin
          res_vld_d = 1'b1;
        end
      end
      ldrs_pkg::CTL_EXEC: begin
        state_d   = ldrs_pkg::CTL_IDLE;
        res_vld_d = 1'b1;
        phase_d   = ldrs_pkg::phase_e'(uw.next_ph);
        case (uw.rs_op)
          ldrs_pkg::BIT_CLR: rs_d = 1'b0;
          ldrs_pkg::BIT_SET: rs_d = 1'b1;
          default:           rs_d = rs_q;
        endcase
        case (uw.en_op)
          ldrs_pkg::BIT_CLR: en_d = 1'b0;
          ldrs_pkg::BIT_SET: en_d = 1'b1;
          default:           en_d = en_q;
        endcase
        case (uw.cmd_op)
          ldrs_pkg::BIT_CLR: cmd_d = 1'b0;
          ldrs_pkg::BIT_SET: cmd_d = 1'b1;
          default:           cmd_d = cmd_q;
        endcase
        case (uw.nib_op)
          ldrs_pkg::NIB_HI: nib_d = byte_out[7:4];
          ldrs_pkg::NIB_LO: nib_d = byte_out[3:0];
          default:          nib_d = nib_q;
        endcase
        case (uw.ivl_sel)
          ldrs_pkg::IVL_SETTLE: ivl_d = settle_ivl_q;
          ldrs_pkg::IVL_SETUP:  ivl_d = setup_ivl_q;
          ldrs_pkg::IVL_PULSE:  ivl_d = pulse_ivl_q;
          default:              ivl_d = ivl_q;
        endcase
        case (uw.jmp)
          ldrs_pkg::JMP_SCAN: begin
            if (shown_cur == wanted_cur) begin
              phase_d = ldrs_pkg::PH_CHECK;
              if (pos_q == AW'(CELLS - 1)) begin
                pos_d = '0;
                row_d = '0;
                col_d = '0;
              end else begin
                pos_d = pos_q + AW'(1);
                if (col_q == CW'(ROW_LENGTH - 1)) begin
                  col_d = '0;
                  row_d = row_q + AW'(1);
                end else begin
                  col_d = col_q + CW'(1);
                end
              end
            end else if (wanted_cur == 8'h00) begin
              phase_d = ldrs_pkg::PH_CHECK;
              w_we    = 1'b1;
              w_wdata = shown_cur;
            end
          end
          ldrs_pkg::JMP_CMD: begin
            if (!cmd_q) begin
              phase_d = ldrs_pkg::PH_CHECK;
              s_we    = 1'b1;
              ivl_d   = scan_ivl_q;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = ldrs_pkg::CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ldrs_pkg::CTL_IDLE;
      phase_q   <= ldrs_pkg::PH_CHECK;
      pos_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      cmd_q     <= 1'b0;
      rs_q      <= 1'b0;
      en_q      <= 1'b0;
      nib_q     <= 4'h0;
      ivl_q     <= ldrs_pkg::ScanIvlRst;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      row_q     <= row_d;
      col_q     <= col_d;
      cmd_q     <= cmd_d;
      rs_q      <= rs_d;
      en_q      <= en_d;
      nib_q     <= nib_d;
      ivl_q     <= ivl_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_ivl_q   <= ldrs_pkg::ScanIvlRst;
      settle_ivl_q <= ldrs_pkg::SettleRst;
      setup_ivl_q  <= ldrs_pkg::SetupRst;
      pulse_ivl_q  <= ldrs_pkg::PulseRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ldrs_pkg::cfg_idx_e'(cfg_index_i))
        ldrs_pkg::CFG_SCAN:   scan_ivl_q   <= cfg_data_i;
        ldrs_pkg::CFG_SETTLE: settle_ivl_q <= cfg_data_i;
        ldrs_pkg::CFG_SETUP:  setup_ivl_q  <= cfg_data_i;
        ldrs_pkg::CFG_PULSE:  pulse_ivl_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // valid bits: an entry never written reads as space
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q    <= '0;
      s_vld_q    <= '0;
      w_rd_vld_q <= 1'b0;
      s_rd_vld_q <= 1'b0;
    end else begin
      if (wr_acc && wr_in_range) begin
        w_vld_q[wr_addr] <= 1'b1;
      end
      if (w_we) begin
        w_vld_q[pos_q] <= 1'b1;
      end
      if (s_we) begin
        s_vld_q[pos_q] <= 1'b1;
      end
      if (tick_acc) begin
        w_rd_vld_q <= w_vld_q[pos_q];
        s_rd_vld_q <= s_vld_q[pos_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_acc && wr_in_range) begin
      wanted_mem[wr_addr] <= item_i.char_code;
    end else if (w_we) begin
      wanted_mem[pos_q] <= w_wdata;
    end
    if (s_we) begin
      shown_mem[pos_q] <= wanted_cur;
    end
    if (tick_acc) begin
      w_rd_q <= wanted_mem[pos_q];
      s_rd_q <= shown_mem[pos_q];
    end
  end

  assign result_valid_o           = res_vld_q;
  assign result_o.reg_select      = rs_q;
  assign result_o.enable_pin      = en_q;
  assign result_o.data_nibble     = nib_q;
  assign result_o.next_interval   = ivl_q;
  assign result_o.refresh_busy    = (phase_q != ldrs_pkg::PH_CHECK);

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ldrs_pkg::CTL_EXEC) |=> result_valid_o)
    else $error("tick finished without result strobe");

  a_phase_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ldrs_pkg::CTL_EXEC) |=> $stable(phase_q))
    else $error("phase moved outside a tick");

  a_enable_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_q |-> (phase_q == ldrs_pkg::PH_HI_EN_OFF || phase_q == ldrs_pkg::PH_LO_EN_OFF))
    else $error("enable high outside an enable pulse");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < CELLS)
    else $error("scan position out of range");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> busy)
    else $error("tick transfer did not start execution");

endmodule
